// ----- sv/stca_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Segment trace clock animator - shared definitions
// Stream widths, the trail entry layout, the result layout and the stroke
// and segment position tables used to draw the time digits.
// ----------------------------------------------------------------------------
package stca_pkg;

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Stroke code that means "no segment this frame"
    localparam logic [2:0] PAUSE = 3'd7;

    // Number of digit positions and strokes per digit
    localparam int NUM_DIGITS = 6;
    localparam int STROKES_PER_DIGIT = 8;

    // Trail memory entry
    typedef struct packed {
        logic       lit;
        logic [1:0] com;
        logic [4:0] seg;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result, last field in the lowest bits
    typedef struct packed {
        logic       done_res;
        logic       pm_on;
        logic       colon_on;
        logic [4:0] clear_seg;
        logic [1:0] clear_com;
        logic       clear_pixel;
        logic [4:0] set_seg;
        logic [1:0] set_com;
        logic       set_pixel;
    } res_t;

    localparam int RES_W = $bits(res_t);

    // Stroke order per digit: segments A..G as 0..6, PAUSE for a rest frame
    localparam logic [2:0] STROKES [10][8] = '{
        '{3'd0, 3'd7, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd7},
        '{3'd1, 3'd7, 3'd7, 3'd7, 3'd2, 3'd7, 3'd7, 3'd7},
        '{3'd0, 3'd1, 3'd6, 3'd4, 3'd7, 3'd7, 3'd7, 3'd3},
        '{3'd0, 3'd1, 3'd6, 3'd7, 3'd7, 3'd7, 3'd2, 3'd3},
        '{3'd5, 3'd7, 3'd6, 3'd1, 3'd7, 3'd7, 3'd7, 3'd2},
        '{3'd0, 3'd7, 3'd5, 3'd7, 3'd6, 3'd7, 3'd2, 3'd3},
        '{3'd0, 3'd7, 3'd5, 3'd4, 3'd3, 3'd2, 3'd7, 3'd6},
        '{3'd0, 3'd7, 3'd7, 3'd1, 3'd7, 3'd7, 3'd2, 3'd7},
        '{3'd0, 3'd5, 3'd6, 3'd2, 3'd3, 3'd4, 3'd7, 3'd1},
        '{3'd0, 3'd5, 3'd6, 3'd1, 3'd7, 3'd7, 3'd2, 3'd3}
    };

    // {com, seg} of segments A..G for each digit position
    localparam logic [6:0] SEG_POS [6][7] = '{
        '{{2'd1, 5'd18}, {2'd2, 5'd19}, {2'd0, 5'd19}, {2'd1, 5'd18},
          {2'd0, 5'd18}, {2'd2, 5'd18}, {2'd1, 5'd19}},
        '{{2'd2, 5'd20}, {2'd2, 5'd21}, {2'd1, 5'd21}, {2'd0, 5'd21},
          {2'd0, 5'd20}, {2'd1, 5'd17}, {2'd1, 5'd20}},
        '{{2'd0, 5'd22}, {2'd2, 5'd23}, {2'd0, 5'd23}, {2'd0, 5'd22},
          {2'd1, 5'd22}, {2'd2, 5'd22}, {2'd1, 5'd23}},
        '{{2'd2, 5'd1},  {2'd2, 5'd10}, {2'd0, 5'd1},  {2'd0, 5'd0},
          {2'd1, 5'd0},  {2'd2, 5'd0},  {2'd1, 5'd1}},
        '{{2'd2, 5'd2},  {2'd2, 5'd3},  {2'd0, 5'd4},  {2'd0, 5'd3},
          {2'd0, 5'd2},  {2'd1, 5'd2},  {2'd1, 5'd3}},
        '{{2'd2, 5'd4},  {2'd2, 5'd5},  {2'd1, 5'd6},  {2'd0, 5'd6},
          {2'd0, 5'd5},  {2'd1, 5'd4},  {2'd1, 5'd5}}
    };

    // Stroke code of a digit at one step; digits above nine rest
    function automatic logic [2:0] stroke_code(input logic [3:0] d, input logic [2:0] step);
        logic [2:0] code;
        code = PAUSE;
        if (d <= 4'd9)
            code = STROKES[d][step];
        return code;
    endfunction

    // {com, seg} of one segment of one digit position
    function automatic logic [6:0] seg_lookup(input logic [2:0] pos, input logic [2:0] code);
        logic [6:0] cs;
        cs = '0;
        if (pos <= 3'd5 && code <= 3'd6)
            cs = SEG_POS[pos][code];
        return cs;
    endfunction

    // Split a value below 64 into {tens, ones}
    function automatic logic [6:0] split_tens(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] base;
        tens = 3'd0;
        base = 6'd0;
        if (v >= 6'd60)
        begin
            tens = 3'd6;
            base = 6'd60;
        end
        else if (v >= 6'd50)
        begin
            tens = 3'd5;
            base = 6'd50;
        end
        else if (v >= 6'd40)
        begin
            tens = 3'd4;
            base = 6'd40;
        end
        else if (v >= 6'd30)
        begin
            tens = 3'd3;
            base = 6'd30;
        end
        else if (v >= 6'd20)
        begin
            tens = 3'd2;
            base = 6'd20;
        end
        else if (v >= 6'd10)
        begin
            tens = 3'd1;
            base = 6'd10;
        end
        return {tens, 4'(v - base)};
    endfunction

endpackage
`default_nettype wire

// ----- sv/stca_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered (old data on a read of
// the entry written at the same edge).
// ----------------------------------------------------------------------------
module stca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- sv/segment_trace_clock_animator_core.sv -----
`default_nettype none
// A result is registered when its tick request is taken. Throughput: one tick per
// cycle while the skid entry is empty; the trail memory is prefetched at the next
// tail address so each tick is one read, at most one write and one table lookup.
// A two-entry output stage keeps s_axis_tready high while one result waits.
// Reset: animation inactive, 12-hour mode; the next tick starts a new animation.
// ----------------------------------------------------------------------------
// Segment trace clock animator
// Draws hh mm ss one segment per tick with a trail of lit segments held in a ring
// memory; clears the oldest segment once the trail is full, save on the final run.
// ----------------------------------------------------------------------------
module segment_trace_clock_animator_core #(
    parameter int TRAIL_LENGTH   = 16,
    parameter int FRAMES_PER_RUN = 64,
    parameter int RUN_COUNT      = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // tdata: hour[4:0], minute[10:5], second[16:11], zero pad
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [stca_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tdata: set_pixel[0], set_com[2:1], set_seg[7:3], clear_pixel[8],
    //        clear_com[10:9], clear_seg[15:11], colon_on[16], pm_on[17],
    //        done_res[18], zero pad
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [stca_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // clock_24h register
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_data
);

    import stca_pkg::*;

    localparam int PW = $clog2(TRAIL_LENGTH);
    localparam int FW = $clog2(FRAMES_PER_RUN + 1);
    localparam int RW = $clog2(RUN_COUNT + 1);
    localparam int DRAW_END = FRAMES_PER_RUN - TRAIL_LENGTH;
    localparam logic [PW-1:0] PTR_LAST = PW'(TRAIL_LENGTH - 1);
    localparam logic [FW-1:0] FRAME_DRAW_END = FW'(DRAW_END);
    localparam logic [FW-1:0] FRAME_RESTART = FW'(FRAMES_PER_RUN);
    localparam logic [RW-1:0] RUNS_INIT = RW'(RUN_COUNT);

    // Ring pointer increment with wrap
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic            clock_24h_reg;
    logic            active_reg,  active_next;
    logic [FW-1:0]   frame_reg,   frame_next;
    logic [2:0]      pos_reg,     pos_next;
    logic [PW-1:0]   head_reg,    head_next;
    logic [PW-1:0]   tail_reg,    tail_next;
    logic            colon_reg,   colon_next;
    logic [RW-1:0]   runs_reg,    runs_next;
    logic            pm_reg,      pm_next;
    logic [3:0]      digit_reg  [NUM_DIGITS];
    logic [3:0]      digit_next [NUM_DIGITS];

    // Forwarding of a write that hits the prefetched tail entry
    logic            fwd_valid_reg, fwd_valid_next;
    entry_t          fwd_data_reg;

    // Output stage
    logic            out_valid_reg, out_valid_next;
    res_t            out_data_reg,  out_data_next;
    logic            skid_valid_reg, skid_valid_next;
    res_t            skid_data_reg,  skid_data_next;

    // Tick datapath
    logic            accept;
    logic            out_pop;
    logic [4:0]      hour_in;
    logic [5:0]      minute_in;
    logic [5:0]      second_in;
    logic [4:0]      hour_disp;
    logic [4:0]      hour_mod;
    logic [6:0]      split_h;
    logic [6:0]      split_m;
    logic [6:0]      split_s;
    logic [3:0]      digit_smp [NUM_DIGITS];
    logic            pm_smp;

    logic [FW-1:0]   frame_e;
    logic [2:0]      pos_e;
    logic [PW-1:0]   head_e;
    logic [PW-1:0]   tail_e;
    logic            colon_e;
    logic [RW-1:0]   runs_e;
    logic            pm_e;
    logic [3:0]      digit_cur;
    logic [2:0]      code;
    logic [6:0]      com_seg;
    logic            ring_full;
    logic            draw;
    logic            restart;
    logic [RW-1:0]   runs_dec;
    entry_t          tail_entry;
    entry_t          ram_q;
    logic            ram_we;
    entry_t          ram_wdata;
    logic [PW-1:0]   ram_raddr;
    res_t            res;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_pop   = out_valid_reg && m_axis_tready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Time sampling: digits from the incoming request
    // ------------------------------------------------------------------
    assign hour_in   = s_axis_tdata[4:0];
    assign minute_in = s_axis_tdata[10:5];
    assign second_in = s_axis_tdata[16:11];

    always_comb
    begin
        pm_smp   = (hour_in >= 5'd12);
        hour_mod = hour_in;
        if (hour_mod >= 5'd12)
            hour_mod = hour_mod - 5'd12;
        if (hour_mod >= 5'd12)
            hour_mod = hour_mod - 5'd12;
        if (hour_mod == 5'd0)
            hour_mod = 5'd12;
        hour_disp = clock_24h_reg ? hour_in : hour_mod;
    end

    assign split_h = split_tens({1'b0, hour_disp});
    assign split_m = split_tens(minute_in);
    assign split_s = split_tens(second_in);

    assign digit_smp[0] = {1'b0, split_h[6:4]};
    assign digit_smp[1] = split_h[3:0];
    assign digit_smp[2] = {1'b0, split_m[6:4]};
    assign digit_smp[3] = split_m[3:0];
    assign digit_smp[4] = {1'b0, split_s[6:4]};
    assign digit_smp[5] = split_s[3:0];

    // ------------------------------------------------------------------
    // Tick: state seen by this tick (fresh on animation start)
    // ------------------------------------------------------------------
    assign frame_e = active_reg ? frame_reg : '0;
    assign pos_e   = active_reg ? pos_reg   : 3'd0;
    assign head_e  = active_reg ? head_reg  : '0;
    assign tail_e  = active_reg ? tail_reg  : '0;
    assign colon_e = active_reg ? colon_reg : 1'b0;
    assign runs_e  = active_reg ? runs_reg  : RUNS_INIT;
    assign pm_e    = (active_reg || clock_24h_reg) ? pm_reg : pm_smp;

    assign digit_cur = active_reg ? digit_reg[pos_e] : digit_smp[pos_e];

    assign draw    = (frame_e < FRAME_DRAW_END);
    assign restart = (frame_e >= FRAME_RESTART);

    // Stroke and segment lookup, leading hour zero blanked in 12-hour mode
    always_comb
    begin
        code = stroke_code(digit_cur, frame_e[2:0]);
        if (pos_e == 3'd0 && digit_cur == 4'd0 && !clock_24h_reg)
            code = PAUSE;
        com_seg = seg_lookup(pos_e, code);
    end

    assign ring_full  = (ptr_inc(head_e) == tail_e);
    assign tail_entry = fwd_valid_reg ? fwd_data_reg : ram_q;
    assign runs_dec   = runs_e - 1'b1;

    // Next state and result
    always_comb
    begin
        active_next = active_reg;
        frame_next  = frame_reg;
        pos_next    = pos_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        colon_next  = colon_reg;
        runs_next   = runs_reg;
        pm_next     = pm_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
            digit_next[i] = digit_reg[i];
        ram_we    = 1'b0;
        ram_wdata = '0;
        res       = '0;

        if (accept)
        begin
            active_next = 1'b1;
            frame_next  = frame_e;
            pos_next    = pos_e;
            head_next   = head_e;
            tail_next   = tail_e;
            colon_next  = colon_e;
            runs_next   = runs_e;
            pm_next     = pm_e;
            if (!active_reg)
            begin
                for (int i = 0; i < NUM_DIGITS; i++)
                    digit_next[i] = digit_smp[i];
            end

            // Pop the oldest trail entry once the ring is full
            if (ring_full)
            begin
                if (tail_entry.lit && runs_e > RW'(1))
                begin
                    res.clear_pixel = 1'b1;
                    res.clear_com   = tail_entry.com;
                    res.clear_seg   = tail_entry.seg;
                end
                tail_next = ptr_inc(tail_e);
            end

            if (draw)
            begin
                // colon flips where frame mod 24 is 12
                if ((pos_e == 3'd1 || pos_e == 3'd4) && frame_e[2:0] == 3'd4)
                    colon_next = ~colon_e;
                ram_we = 1'b1;
                if (code != PAUSE)
                begin
                    res.set_pixel = 1'b1;
                    res.set_com   = com_seg[6:5];
                    res.set_seg   = com_seg[4:0];
                    ram_wdata     = '{lit: 1'b1, com: com_seg[6:5], seg: com_seg[4:0]};
                end
                head_next = ptr_inc(head_e);
            end
            else if (!restart)
            begin
                head_next = ptr_inc(head_e);
            end

            if (restart)
            begin
                runs_next  = runs_dec;
                frame_next = '0;
                pos_next   = 3'd0;
                if (runs_dec == '0)
                begin
                    res.done_res = 1'b1;
                    active_next  = 1'b0;
                end
                else
                begin
                    for (int i = 0; i < NUM_DIGITS; i++)
                        digit_next[i] = digit_smp[i];
                    if (!clock_24h_reg)
                        pm_next = pm_smp;
                end
            end
            else
            begin
                frame_next = frame_e + 1'b1;
                if (frame_e[2:0] == 3'd7)
                    pos_next = (pos_e == 3'd5) ? 3'd0 : pos_e + 3'd1;
            end

            res.colon_on = colon_next;
            res.pm_on    = pm_next;
        end
    end

    // ------------------------------------------------------------------
    // Trail memory: prefetch the entry at the tail the next tick will see
    // ------------------------------------------------------------------
    assign ram_raddr      = accept ? tail_next : tail_reg;
    assign fwd_valid_next = ram_we && (head_e == ram_raddr);

    stca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TRAIL_LENGTH)
    ) u_trail_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_e),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
    end

    // ------------------------------------------------------------------
    // Output stage: result register plus skid entry
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (accept)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_data_reg};

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_24h_reg  <= 1'b0;
            active_reg     <= 1'b0;
            frame_reg      <= '0;
            pos_reg        <= 3'd0;
            head_reg       <= '0;
            tail_reg       <= '0;
            colon_reg      <= 1'b0;
            runs_reg       <= RUNS_INIT;
            pm_reg         <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
                digit_reg[i] <= 4'd0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                clock_24h_reg <= cfg_data;
            active_reg     <= active_next;
            frame_reg      <= frame_next;
            pos_reg        <= pos_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            colon_reg      <= colon_next;
            runs_reg       <= runs_next;
            pm_reg         <= pm_next;
            for (int i = 0; i < NUM_DIGITS; i++)
                digit_reg[i] <= digit_next[i];
            fwd_valid_reg  <= fwd_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg <= FRAME_RESTART)
        else $error("frame counter beyond restart tick");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.done_res) |=> !active_reg)
        else $error("animation still active after done");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= PTR_LAST && tail_reg <= PTR_LAST)
        else $error("trail pointer out of range");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment trace clock animator - stream testbench
// Feeds animation tick requests carrying hh:mm:ss, predicts every drawn and
// cleared segment, the colon, PM and done flags in its own model of the
// animator, and checks each result request field by field. Both stream sides
// idle at random, the receiver is held off once to fill the block, and the
// 12/24-hour register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TRAIL_LEN      = 16;
    localparam int FRAMES_PER_RUN = 64;
    localparam int RUN_COUNT      = 4;
    localparam int DRAW_END       = FRAMES_PER_RUN - TRAIL_LEN;
    localparam logic [2:0] STROKE_REST = 3'd7;
    localparam int GAP_PERCENT    = 36;
    localparam int SINK_HOLD_CYCLES = 100;

    typedef stca_pkg::res_t frame_res_t;

    // One tick request, hour in the lowest bits
    typedef struct packed {
        logic [5:0] sc;
        logic [5:0] mn;
        logic [4:0] hr;
    } clock_time_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [stca_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [stca_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic                              cfg_data = 1'b0;

    segment_trace_clock_animator_core #(
        .TRAIL_LENGTH   (TRAIL_LEN),
        .FRAMES_PER_RUN (FRAMES_PER_RUN),
        .RUN_COUNT      (RUN_COUNT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stimulus and check bookkeeping
    clock_time_t ticks_to_send [$];
    frame_res_t  frames_due [$];
    logic        steady = 1'b0;      // no idling on either side
    logic        sink_hold = 1'b0;   // receiver held off
    int          ticks_sent = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          lit_seen = 0;
    int          cleared_seen = 0;
    int          done_seen = 0;

    // Animator model state
    logic        mode_24h = 1'b0;
    logic        anim_active = 1'b0;
    int          frame_no = 0;
    int          trail_head = 0;
    int          trail_tail = 0;
    logic        colon_level = 1'b0;
    logic        pm_level = 1'b0;
    int          runs_left = RUN_COUNT;
    logic [3:0]  digits [6];
    logic [7:0]  trail [TRAIL_LEN];

    // Stroke order per digit, frame 0 in the top nibble; 7 is a rest frame
    function automatic logic [2:0] stroke_of(input logic [3:0] dig, input int step);
        logic [31:0] row;
        case (dig)
            4'd0:    row = 32'h0754_3217;
            4'd1:    row = 32'h1777_2777;
            4'd2:    row = 32'h0164_7773;
            4'd3:    row = 32'h0167_7723;
            4'd4:    row = 32'h5761_7772;
            4'd5:    row = 32'h0757_6723;
            4'd6:    row = 32'h0754_3276;
            4'd7:    row = 32'h0771_7727;
            4'd8:    row = 32'h0562_3471;
            4'd9:    row = 32'h0561_7723;
            default: row = 32'h7777_7777;
        endcase
        return row[4 * (7 - step) +: 3];
    endfunction

    // {com, seg} of segments A..G per digit position, segment A in the top byte
    function automatic logic [6:0] segment_of(input int pos, input logic [2:0] code);
        logic [55:0] row;
        case (pos)
            0:       row = 56'h32_53_13_32_12_52_33;
            1:       row = 56'h54_55_35_15_14_31_34;
            2:       row = 56'h16_57_17_16_36_56_37;
            3:       row = 56'h41_4A_01_00_20_40_21;
            4:       row = 56'h42_43_04_03_02_22_23;
            default: row = 56'h44_45_26_06_05_24_25;
        endcase
        return row[8 * (6 - code) +: 7];
    endfunction

    // Split the sampled time into six digits, 12-hour folding as configured
    task automatic latch_time(input clock_time_t t);
        int h;
        h = t.hr;
        if (!mode_24h)
        begin
            pm_level = (h >= 12);
            h = h % 12;
            if (h == 0)
                h = 12;
        end
        digits[0] = 4'(h / 10);
        digits[1] = 4'(h % 10);
        digits[2] = 4'(t.mn / 10);
        digits[3] = 4'(t.mn % 10);
        digits[4] = 4'(t.sc / 10);
        digits[5] = 4'(t.sc % 10);
    endtask

    // Advance the animation by one tick and work out its result
    task automatic animate_tick(input clock_time_t t, output frame_res_t r);
        int         pos;
        logic [3:0] dig;
        logic [2:0] code;
        logic [6:0] cs;
        logic [7:0] oldest;
        r = '0;
        if (!anim_active)
        begin
            anim_active = 1'b1;
            colon_level = 1'b0;
            frame_no = 0;
            trail_head = 0;
            trail_tail = 0;
            runs_left = RUN_COUNT;
            latch_time(t);
        end
        // trail full: pop the oldest, clearing it unless on the final run
        if ((trail_head + 1) % TRAIL_LEN == trail_tail)
        begin
            oldest = trail[trail_tail];
            if (oldest[7] && runs_left > 1)
            begin
                r.clear_pixel = 1'b1;
                r.clear_com = oldest[6:5];
                r.clear_seg = oldest[4:0];
            end
            trail_tail = (trail_tail + 1) % TRAIL_LEN;
        end
        if (frame_no < DRAW_END)
        begin
            if (frame_no % 24 == 12)
                colon_level = !colon_level;
            pos = (frame_no / 8) % 6;
            dig = digits[pos];
            code = stroke_of(dig, frame_no % 8);
            // leading zero hour blanked in 12-hour mode
            if (pos == 0 && dig == 4'd0 && !mode_24h)
                code = STROKE_REST;
            if (code == STROKE_REST)
                trail[trail_head] = 8'h00;
            else
            begin
                cs = segment_of(pos, code);
                r.set_pixel = 1'b1;
                r.set_com = cs[6:5];
                r.set_seg = cs[4:0];
                trail[trail_head] = {1'b1, cs};
            end
            trail_head = (trail_head + 1) % TRAIL_LEN;
            frame_no++;
        end
        else if (frame_no < FRAMES_PER_RUN)
        begin
            trail_head = (trail_head + 1) % TRAIL_LEN;
            frame_no++;
        end
        else
        begin
            // restart tick: ring head holds still
            runs_left--;
            frame_no = 0;
            if (runs_left == 0)
            begin
                r.done_res = 1'b1;
                anim_active = 1'b0;
            end
            else
                latch_time(t);
        end
        r.colon_on = colon_level;
        r.pm_on = pm_level;
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("tb_top: mismatch at result %0d (%0t): %s", results_seen, $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic clock_time_t pick_time();
        clock_time_t t;
        if ($urandom_range(99) < 70)
        begin
            t.hr = 5'($urandom_range(23));
            t.mn = 6'($urandom_range(59));
            t.sc = 6'($urandom_range(59));
        end
        else
            t = 17'($urandom_range(17'h1FFFF));
        return t;
    endfunction

    function automatic clock_time_t time_of(input int h, input int m, input int s);
        clock_time_t t;
        t.hr = 5'(h);
        t.mn = 6'(m);
        t.sc = 6'(s);
        return t;
    endfunction

    // Driver: predicts each taken tick request, then offers the next one
    always @(posedge clk)
    begin : drive_ticks
        frame_res_t  want;
        clock_time_t nxt;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                animate_tick(clock_time_t'(s_axis_tdata[16:0]), want);
                frames_due.push_back(want);
                ticks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (ticks_to_send.size() > 0
                    && (steady || $urandom_range(99) >= GAP_PERCENT))
                begin
                    nxt = ticks_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {7'b0, nxt};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each taken result request against the oldest prediction
    always @(posedge clk)
    begin : watch_frames
        frame_res_t got;
        frame_res_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = frame_res_t'(m_axis_tdata[stca_pkg::RES_W-1:0]);
                if (frames_due.size() == 0)
                    report_mismatch("result with no tick waiting");
                else
                begin
                    want = frames_due.pop_front();
                    check_field("set_pixel", got.set_pixel, want.set_pixel);
                    check_field("set_com", got.set_com, want.set_com);
                    check_field("set_seg", got.set_seg, want.set_seg);
                    check_field("clear_pixel", got.clear_pixel, want.clear_pixel);
                    check_field("clear_com", got.clear_com, want.clear_com);
                    check_field("clear_seg", got.clear_seg, want.clear_seg);
                    check_field("colon_on", got.colon_on, want.colon_on);
                    check_field("pm_on", got.pm_on, want.pm_on);
                    check_field("done_res", got.done_res, want.done_res);
                    lit_seen += want.set_pixel;
                    cleared_seen += want.clear_pixel;
                    done_seen += want.done_res;
                end
                results_seen++;
            end
            m_axis_tready <= !sink_hold && (steady || $urandom_range(99) >= GAP_PERCENT);
        end
    end

    // Receiver hold-off long enough to back the block up to its input
    initial
    begin
        while (ticks_sent < 250)
            @(posedge clk);
        sink_hold <= 1'b1;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Wait until every tick is taken and every result is back;
    // sampled mid-cycle so the driver's updates have settled
    task automatic drain();
        while (ticks_to_send.size() > 0 || s_axis_tvalid || frames_due.size() > 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_clock_mode(input logic mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_24h = mode;
    endtask

    initial
    begin : stimulus
        logic phase_mode [4];
        int   phase_len [4];
        phase_mode = '{1'b1, 1'b0, 1'b1, 1'b0};
        phase_len = '{150, 150, 140, 140};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes; the first tick samples a blanked PM hour
        ticks_to_send.push_back(time_of(31, 63, 63));
        ticks_to_send.push_back(time_of(0, 0, 0));
        ticks_to_send.push_back(time_of(23, 59, 59));
        ticks_to_send.push_back(time_of(12, 0, 0));
        ticks_to_send.push_back(time_of(11, 59, 59));
        ticks_to_send.push_back(time_of(1, 1, 1));
        ticks_to_send.push_back(time_of(16, 42, 21));
        ticks_to_send.push_back(time_of(31, 0, 63));
        ticks_to_send.push_back(time_of(0, 63, 0));
        for (int i = 0; i < 16; i++)
            ticks_to_send.push_back(i % 2 ? time_of(5'h15, 6'h2A, 6'h15)
                                          : time_of(5'h0A, 6'h15, 6'h2A));
        drain();

        // Random phases, each under its own clock mode
        for (int p = 0; p < 4; p++)
        begin
            write_clock_mode(phase_mode[p]);
            steady = (p == 1);
            for (int i = 0; i < phase_len[p]; i++)
                ticks_to_send.push_back(pick_time());
            drain();
        end

        if (frames_due.size() > 0)
            report_mismatch("predicted results never arrived");
        $display("tb_top: %0d ticks checked in both clock modes: %0d lit, %0d cleared,",
                 results_seen, lit_seen, cleared_seen);
        $display("tb_top: %0d animations finished, %0d mismatches", done_seen, mismatches);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #200_000;
        $display("tb_top: timeout with %0d results outstanding", frames_due.size());
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
